>>> sv/line_position_pid_steering_top_defines.svh
// ----------------------------------------------------------------------------
// line_position_pid_steering_top_defines
// Assertion macros shared by the steering checker.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PID_STEERING_TOP_DEFINES_SVH
`define LINE_POSITION_PID_STEERING_TOP_DEFINES_SVH

// antecedent holds -> consequent holds on the next clock
`define LPPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds on the same clock
`define LPPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared constants, types and helpers for the line position PID steering block.
// ----------------------------------------------------------------------------
package lpps_pkg;

    // sensor row
    localparam int SENSOR_COUNT = 8;
    localparam int SENSOR_PITCH = 1000;
    localparam int SENSOR_W     = 8;
    localparam int SCAN_W       = (SENSOR_COUNT > SENSOR_W) ? SENSOR_COUNT : SENSOR_W;
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int IDX_SUM_MAX  = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
    localparam int IDX_W        = $clog2(IDX_SUM_MAX + 1);
    localparam int WSUM_MAX     = IDX_SUM_MAX * SENSOR_PITCH;
    localparam int WSUM_W       = $clog2(WSUM_MAX + 1);
    localparam int STEP_W       = $clog2(WSUM_W + 1);

    // field widths
    localparam int GAIN_W = 24;
    localparam int DUTY_W = 14;
    localparam int POS_W  = 13;
    localparam int ERR_W  = 14;
    localparam int DOT_W  = 15;
    localparam int ACC_W  = 32;
    localparam int Q_FRAC = 16;
    localparam int PROD_W = GAIN_W + 1 + ACC_W;
    localparam int SUM_W  = 58;
    localparam int HI_W   = SUM_W - Q_FRAC;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // register port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_DUTY   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DUTY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_POS  = 3'd5;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integral;
        logic [GAIN_W-1:0] gain_deriv;
        logic [DUTY_W-1:0] base_duty;
        logic [DUTY_W-1:0] max_duty;
        logic [POS_W-1:0]  target_position;
    } cfg_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    function automatic logic [POS_W-1:0] sat_pos(input logic [WSUM_W-1:0] q);
        if (32'(q) > 32'(POS_MAX))
        begin
            return POS_MAX;
        end
        return POS_W'(q);
    endfunction

    // Q16 value to duty count, clamped to 0..maxd
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] q,
                                                     input logic [DUTY_W-1:0] maxd);
        logic [HI_W-1:0] hi;
        hi = q[SUM_W-1:Q_FRAC];
        if (q[SUM_W-1])
        begin
            return '0;
        end
        if (hi > HI_W'(maxd))
        begin
            return maxd;
        end
        return hi[DUTY_W-1:0];
    endfunction

endpackage

>>> sv/lpps_regs.sv
// ----------------------------------------------------------------------------
// lpps_regs
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module lpps_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpps_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpps_pkg::DATA_W-1:0]    pwdata,
    output logic [lpps_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output lpps_pkg::cfg_t                 cfg
);

    lpps_pkg::cfg_t cfg_reg;
    lpps_pkg::cfg_t cfg_next;
    logic [lpps_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[lpps_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                lpps_pkg::REG_GAIN_PROP:
                    cfg_next.gain_prop = pwdata[lpps_pkg::GAIN_W-1:0];
                lpps_pkg::REG_GAIN_INTEG:
                    cfg_next.gain_integral = pwdata[lpps_pkg::GAIN_W-1:0];
                lpps_pkg::REG_GAIN_DERIV:
                    cfg_next.gain_deriv = pwdata[lpps_pkg::GAIN_W-1:0];
                lpps_pkg::REG_BASE_DUTY:
                    cfg_next.base_duty = pwdata[lpps_pkg::DUTY_W-1:0];
                lpps_pkg::REG_MAX_DUTY:
                    cfg_next.max_duty = pwdata[lpps_pkg::DUTY_W-1:0];
                lpps_pkg::REG_TARGET_POS:
                    cfg_next.target_position = pwdata[lpps_pkg::POS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            lpps_pkg::REG_GAIN_PROP:  prdata = lpps_pkg::DATA_W'(cfg_reg.gain_prop);
            lpps_pkg::REG_GAIN_INTEG: prdata = lpps_pkg::DATA_W'(cfg_reg.gain_integral);
            lpps_pkg::REG_GAIN_DERIV: prdata = lpps_pkg::DATA_W'(cfg_reg.gain_deriv);
            lpps_pkg::REG_BASE_DUTY:  prdata = lpps_pkg::DATA_W'(cfg_reg.base_duty);
            lpps_pkg::REG_MAX_DUTY:   prdata = lpps_pkg::DATA_W'(cfg_reg.max_duty);
            lpps_pkg::REG_TARGET_POS: prdata = lpps_pkg::DATA_W'(cfg_reg.target_position);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop       <= 24'd45875;
            cfg_reg.gain_integral   <= 24'd524;
            cfg_reg.gain_deriv      <= 24'd393216;
            cfg_reg.base_duty       <= 14'd500;
            cfg_reg.max_duty        <= 14'd1000;
            cfg_reg.target_position <= 13'd3500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/lpps_div.sv
// ----------------------------------------------------------------------------
// lpps_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpps_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpps_pkg::WSUM_W-1:0]   dividend,
    input  logic [lpps_pkg::CNT_W-1:0]    divisor,
    output logic [lpps_pkg::WSUM_W-1:0]   quotient,
    output logic                          done
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lpps_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [lpps_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [lpps_pkg::CNT_W-1:0]    dvs_reg, dvs_next;
    logic [lpps_pkg::WSUM_W-1:0]   quo_reg, quo_next;
    logic [lpps_pkg::CNT_W:0]      rem_shift;
    logic                          ge;

    assign rem_shift = {rem_reg, quo_reg[lpps_pkg::WSUM_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign quotient  = quo_reg;
    assign done      = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? lpps_pkg::CNT_W'(rem_shift - {1'b0, dvs_reg})
                           : rem_shift[lpps_pkg::CNT_W-1:0];
            quo_next  = (quo_reg << 1) | lpps_pkg::WSUM_W'(ge);
            step_next = step_reg + lpps_pkg::STEP_W'(1);
            if (step_reg == lpps_pkg::STEP_W'(lpps_pkg::WSUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

endmodule

>>> sv/lpps_mac.sv
// ----------------------------------------------------------------------------
// lpps_mac
// Shared gain multiplier with registered product and Q16 accumulator.
// ----------------------------------------------------------------------------
module lpps_mac
(
    input  logic                               clk,
    input  lpps_pkg::mac_ctrl_t                ctrl,
    input  logic [lpps_pkg::GAIN_W-1:0]        gain,
    input  logic signed [lpps_pkg::ACC_W-1:0]  opnd,
    output logic signed [lpps_pkg::SUM_W-1:0]  sum
);

    logic signed [lpps_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [lpps_pkg::SUM_W-1:0]  sum_reg, sum_next;

    assign sum = sum_reg;

    always_comb
    begin
        prod_next = prod_reg;
        sum_next  = sum_reg;
        if (ctrl.mul_en)
        begin
            prod_next = $signed({1'b0, gain}) * opnd;
        end
        if (ctrl.clr)
        begin
            sum_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            sum_next = sum_reg + lpps_pkg::SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

endmodule

>>> sv/line_position_pid_steering_top.sv
// ----------------------------------------------------------------------------
// line_position_pid_steering_top
// Line-sensor centroid, PID correction and differential duty clamp.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  -------   ---   ---------------------  ----------------------------------
//  in        in    in_valid / in_stall    sensor_bits
//  out       out   out_valid / out_stall  left_duty, right_duty, line_position
//  cfg       in    psel/penable/pwrite    paddr, pwdata -> prdata, pready
//
//  An item with a dark sensor goes through the serial divider, which computes
//  the centroid one bit per cycle; an item with no dark sensor skips the
//  divider. The three PID terms then go one after another through a single
//  multiplier.
//  in_stall is high from acceptance until the result is written out.
//  A result waiting under out_stall holds; the next item may be accepted
//  meanwhile but its result waits until the output register is free.
//  rst_n is asynchronous; it clears the sequencer and PID state, presets config.
//
module line_position_pid_steering_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lpps_pkg::SENSOR_W-1:0] sensor_bits,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lpps_pkg::DUTY_W-1:0]   left_duty,
    output logic [lpps_pkg::DUTY_W-1:0]   right_duty,
    output logic [lpps_pkg::POS_W-1:0]    line_position,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpps_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpps_pkg::DATA_W-1:0]   pwdata,
    output logic [lpps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] S_DIV  = 3'd1;  // centroid divide
    localparam logic [2:0] S_ERR  = 3'd2;  // error, integral, derivative
    localparam logic [2:0] S_M0   = 3'd3;  // proportional product
    localparam logic [2:0] S_M1   = 3'd4;  // integral product
    localparam logic [2:0] S_M2   = 3'd5;  // derivative product
    localparam logic [2:0] S_M3   = 3'd6;  // last accumulate
    localparam logic [2:0] S_OUT  = 3'd7;  // clamp and present

    lpps_pkg::cfg_t cfg;

    logic [2:0] state_reg, state_next;

    // PID state
    logic [lpps_pkg::POS_W-1:0]         held_reg, held_next;
    logic signed [lpps_pkg::ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic signed [lpps_pkg::ACC_W-1:0]  acc_reg, acc_next;

    // per-item working registers
    logic                               dark_all_reg, dark_all_next;
    logic [lpps_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic signed [lpps_pkg::ERR_W-1:0]  err_reg, err_next;
    logic signed [lpps_pkg::DOT_W-1:0]  dot_reg, dot_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [lpps_pkg::DUTY_W-1:0]        left_reg, left_next;
    logic [lpps_pkg::DUTY_W-1:0]        right_reg, right_next;
    logic [lpps_pkg::POS_W-1:0]         line_pos_reg, line_pos_next;

    // sensor scan
    logic [lpps_pkg::SCAN_W-1:0]        scan;
    logic [lpps_pkg::CNT_W-1:0]         dark_cnt;
    logic [lpps_pkg::IDX_W-1:0]         idx_sum;
    logic [lpps_pkg::WSUM_W-1:0]        weighted;

    // divider
    logic                               div_start;
    logic [lpps_pkg::WSUM_W-1:0]        div_quo;
    logic                               div_done;

    // error path
    logic signed [lpps_pkg::ERR_W-1:0]  err_calc;
    logic signed [lpps_pkg::DOT_W-1:0]  dot_calc;
    logic signed [lpps_pkg::ACC_W:0]    acc_wide;
    logic signed [lpps_pkg::ACC_W-1:0]  acc_sat;

    // multiplier
    lpps_pkg::mac_ctrl_t                mac_ctrl;
    logic [lpps_pkg::GAIN_W-1:0]        mac_gain;
    logic signed [lpps_pkg::ACC_W-1:0]  mac_opnd;
    logic signed [lpps_pkg::SUM_W-1:0]  mac_sum;

    // duty path
    logic signed [lpps_pkg::SUM_W-1:0]  base_q;
    logic signed [lpps_pkg::SUM_W-1:0]  left_q;
    logic signed [lpps_pkg::SUM_W-1:0]  right_q;

    lpps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (weighted),
        .divisor  (dark_cnt),
        .quotient (div_quo),
        .done     (div_done)
    );

    lpps_mac u_mac
    (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .gain (mac_gain),
        .opnd (mac_opnd),
        .sum  (mac_sum)
    );

    // dark count and index sum over the sensor row; bits past the port read light
    assign scan = lpps_pkg::SCAN_W'(sensor_bits);

    always_comb
    begin
        dark_cnt = '0;
        idx_sum  = '0;
        for (int k = 0; k < lpps_pkg::SENSOR_COUNT; k++)
        begin
            if (scan[k])
            begin
                dark_cnt = dark_cnt + lpps_pkg::CNT_W'(1);
                idx_sum  = idx_sum + lpps_pkg::IDX_W'(k);
            end
        end
    end

    assign weighted = lpps_pkg::WSUM_W'(32'(idx_sum) * 32'(lpps_pkg::SENSOR_PITCH));

    // error = target - position, integral saturates at 32-bit limits
    assign err_calc = $signed({1'b0, cfg.target_position}) - $signed({1'b0, pos_reg});
    assign dot_calc = lpps_pkg::DOT_W'(err_calc) - lpps_pkg::DOT_W'(prev_err_reg);
    assign acc_wide = (lpps_pkg::ACC_W + 1)'(acc_reg) + (lpps_pkg::ACC_W + 1)'(err_calc);

    always_comb
    begin
        if (acc_wide[lpps_pkg::ACC_W] != acc_wide[lpps_pkg::ACC_W-1])
        begin
            acc_sat = acc_wide[lpps_pkg::ACC_W] ? lpps_pkg::ACC_MIN : lpps_pkg::ACC_MAX;
        end
        else
        begin
            acc_sat = $signed(acc_wide[lpps_pkg::ACC_W-1:0]);
        end
    end

    // base +/- correction in Q16
    assign base_q  = $signed(lpps_pkg::SUM_W'(cfg.base_duty) << lpps_pkg::Q_FRAC);
    assign left_q  = base_q - mac_sum;
    assign right_q = base_q + mac_sum;

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        prev_err_next  = prev_err_reg;
        acc_next       = acc_reg;
        dark_all_next  = dark_all_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        dot_next       = dot_reg;
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        line_pos_next  = line_pos_reg;
        div_start      = 1'b0;
        mac_ctrl       = '0;
        mac_gain       = '0;
        mac_opnd       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dark_all_next = (dark_cnt == lpps_pkg::CNT_W'(lpps_pkg::SENSOR_COUNT));
                    if (dark_cnt != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // no line seen: keep the last position
                        pos_next   = held_reg;
                        state_next = S_ERR;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pos_next   = lpps_pkg::sat_pos(div_quo);
                    held_next  = lpps_pkg::sat_pos(div_quo);
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                err_next      = err_calc;
                dot_next      = dot_calc;
                acc_next      = acc_sat;
                prev_err_next = err_calc;
                mac_ctrl.clr  = 1'b1;
                state_next    = S_M0;
            end
            S_M0:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_gain        = cfg.gain_prop;
                mac_opnd        = lpps_pkg::ACC_W'(err_reg);
                state_next      = S_M1;
            end
            S_M1:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                mac_gain        = cfg.gain_integral;
                mac_opnd        = acc_reg;
                state_next      = S_M2;
            end
            S_M2:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                mac_gain        = cfg.gain_deriv;
                mac_opnd        = lpps_pkg::ACC_W'(dot_reg);
                state_next      = S_M3;
            end
            S_M3:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    // every sensor dark: stop both motors
                    left_next      = dark_all_reg ? '0
                                                  : lpps_pkg::clamp_duty(left_q, cfg.max_duty);
                    right_next     = dark_all_reg ? '0
                                                  : lpps_pkg::clamp_duty(right_q, cfg.max_duty);
                    line_pos_next  = pos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign left_duty     = left_reg;
    assign right_duty    = right_reg;
    assign line_position = line_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            prev_err_reg  <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            prev_err_reg  <= prev_err_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dark_all_reg <= dark_all_next;
        pos_reg      <= pos_next;
        err_reg      <= err_next;
        dot_reg      <= dot_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        line_pos_reg <= line_pos_next;
    end

endmodule

>>> sv/lpps_chk.sv
// ----------------------------------------------------------------------------
// lpps_chk
// Port-level checks on the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_position_pid_steering_top_defines.svh"

module lpps_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lpps_pkg::DUTY_W-1:0]   left_duty,
    input logic [lpps_pkg::DUTY_W-1:0]   right_duty,
    input logic [lpps_pkg::POS_W-1:0]    line_position
);

    // one item at a time: busy right after taking an item
    `LPPS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "not busy after item")

    // a result never shows up the cycle after an item is taken
    `LPPS_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "early result")

    // a taken result is not followed at once by another
    `LPPS_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid, "result repeated")

    // a stalled result holds
    `LPPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(left_duty) && $stable(right_duty) && $stable(line_position),
        "stalled result changed")

endmodule

bind line_position_pid_steering_top lpps_chk u_lpps_chk (.*);
